// ===== design/spg_pkg.sv =====
// Shared constants, types and the stress floor table for the syllable pitch gradient block.
package spg_pkg;

    localparam int unsigned MAX_RUN_DEF = 255;

    localparam int PITCH_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int STRESS_W = 3;
    localparam int FRAC_W   = 8;
    localparam int ACC_W    = 18;
    localparam int DROP_W   = 9;
    localparam int DIV_W    = PITCH_W + FRAC_W;
    localparam int INT_W    = ACC_W - FRAC_W;
    localparam int FLOOR_W  = 5;

    localparam int unsigned DROP_CAP = 18;

    typedef enum logic [0:0] {
        CMD_START    = 1'b0,
        CMD_SYLLABLE = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } t_state;

    typedef struct packed {
        logic                     rising;
        logic signed [DROP_W-1:0] drop;
    } t_drop_res;

    // Minimum pitch drop for each stress level.
    function automatic logic [FLOOR_W-1:0] min_drop(input logic [STRESS_W-1:0] stress);
        logic [FLOOR_W-1:0] v;
        case (stress)
            3'd0:    v = 5'd6;
            3'd1:    v = 5'd7;
            3'd2:    v = 5'd9;
            3'd3:    v = 5'd9;
            3'd4:    v = 5'd20;
            3'd5:    v = 5'd20;
            3'd6:    v = 5'd20;
            3'd7:    v = 5'd25;
            default: v = 5'd6;
        endcase
        return v;
    endfunction

endpackage

// ===== design/spg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
module spg_div import spg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic [COUNT_W-1:0] r_dvs, n_dvs;
    logic [DIV_W-1:0]   r_quo, n_quo;

    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               fits;

    // The dividend shifts out of the top of r_quo as quotient bits shift in below.
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/spg_drop.sv =====
// Pitch drop shaping: negated integer step, stress floor and cap on falling slopes.
module spg_drop import spg_pkg::*; (
    input  logic signed [ACC_W-1:0]    i_step,
    input  logic        [STRESS_W-1:0] i_stress,
    output t_drop_res                  o_res
);

    localparam logic signed [INT_W-1:0] CAP_V = INT_W'(DROP_CAP);

    logic signed [INT_W-1:0] int_part;
    logic signed [INT_W-1:0] neg_int;
    logic signed [INT_W-1:0] floor_v;
    logic signed [INT_W-1:0] raised;
    logic signed [INT_W-1:0] capped;
    logic                    rising;

    // The upper bits of the step are its floor after an arithmetic shift by the fraction.
    assign int_part = i_step[ACC_W-1:FRAC_W];
    assign neg_int  = -int_part;
    assign floor_v  = {{(INT_W-FLOOR_W){1'b0}}, min_drop(i_stress)};
    assign raised   = (neg_int < floor_v) ? floor_v : neg_int;
    assign capped   = (raised > CAP_V) ? CAP_V : raised;
    assign rising   = !i_step[ACC_W-1] && (i_step != '0);

    assign o_res.rising = rising;
    assign o_res.drop   = rising ? neg_int[DROP_W-1:0] : capped[DROP_W-1:0];

endmodule

// ===== design/syllable_pitch_gradient_top.sv =====
// Top level: command decode, pitch accumulator, serial step divide and output register.
// A start item occupies the block through the divider load, its 16 bit steps and the done flag;
// it produces no result and input stall stays high until the step is stored.
// A syllable item's result appears in the output register in the cycle after it is accepted.
// Syllable items may follow back to back while the output register drains.
// Synchronous active-low reset clears the state, accumulator, step, syllable count and output valid.
module syllable_pitch_gradient_top import spg_pkg::*; #(
    parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic [PITCH_W-1:0]       i_pitch_start,
    input  logic [PITCH_W-1:0]       i_pitch_end,
    input  logic [COUNT_W-1:0]       i_syllable_count,
    input  logic [STRESS_W-1:0]      i_stress_level,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PITCH_W-1:0]       o_base_pitch,
    output logic signed [DROP_W-1:0] o_pitch_drop,
    output logic                     o_last_syllable
);

    t_state r_state, n_state;

    logic [ACC_W-1:0]          r_acc, n_acc;
    logic signed [ACC_W-1:0]   r_step, n_step;
    logic [COUNT_W-1:0]        r_left, n_left;
    logic                      r_neg, n_neg;
    logic                      r_out_valid, n_out_valid;
    logic [PITCH_W-1:0]        r_base, n_base;
    logic signed [DROP_W-1:0]  r_drop, n_drop;
    logic                      r_last, n_last;

    logic                      in_acc;
    logic                      out_take;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quo;
    logic [DIV_W-1:0]          dividend;
    logic [COUNT_W-1:0]        n_sat;
    logic [COUNT_W-1:0]        divisor;
    logic [PITCH_W:0]          diff9;
    logic [PITCH_W:0]          mag9;
    logic [ACC_W-1:0]          acc_sum;
    logic [ACC_W-1:0]          quo_ext;
    t_drop_res                 drop_res;

    assign o_stall  = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign in_acc   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    assign n_sat    = (32'(i_syllable_count) > MAX_RUN) ? MAX_RUN[COUNT_W-1:0]
                                                         : i_syllable_count;
    assign divisor  = (n_sat > COUNT_W'(1)) ? n_sat : COUNT_W'(1);
    assign diff9    = {1'b0, i_pitch_end} - {1'b0, i_pitch_start};
    assign mag9     = diff9[PITCH_W] ? -diff9 : diff9;
    assign dividend = {mag9[PITCH_W-1:0], {FRAC_W{1'b0}}};
    assign div_start = in_acc && (t_cmd'(i_cmd) == CMD_START);

    assign acc_sum  = r_acc + r_step;
    assign quo_ext  = {{(ACC_W-DIV_W){1'b0}}, div_quo};

    spg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    spg_drop u_drop (
        .i_step   (r_step),
        .i_stress (i_stress_level),
        .o_res    (drop_res)
    );

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_step      = r_step;
        n_left      = r_left;
        n_neg       = r_neg;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_base      = r_base;
        n_drop      = r_drop;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (t_cmd'(i_cmd) == CMD_START) begin
                        n_acc   = {{(ACC_W-PITCH_W-FRAC_W){1'b0}}, i_pitch_start,
                                   {FRAC_W{1'b0}}};
                        n_left  = n_sat;
                        n_neg   = diff9[PITCH_W];
                        n_state = ST_DIV;
                    end else if (r_left != '0) begin
                        // A rising slope reports the pitch before the step, a falling one after.
                        n_acc       = acc_sum;
                        n_base      = drop_res.rising ? r_acc[FRAC_W +: PITCH_W]
                                                      : acc_sum[FRAC_W +: PITCH_W];
                        n_drop      = drop_res.drop;
                        n_last      = (r_left == COUNT_W'(1));
                        n_left      = r_left - 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_step  = r_neg ? -quo_ext : quo_ext;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_step      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_step      <= n_step;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_neg  <= n_neg;
        r_base <= n_base;
        r_drop <= n_drop;
        r_last <= n_last;
    end

    assign o_valid         = r_out_valid;
    assign o_base_pitch    = r_base;
    assign o_pitch_drop    = r_drop;
    assign o_last_syllable = r_last;

    a_result_from_syllable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc && (t_cmd'(i_cmd) == CMD_SYLLABLE)))
        else $error("result appeared without an accepted syllable item");

    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_DIV))
        else $error("start item did not begin the step divide");

    a_div_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_DIV) && (r_state == ST_DIV) |-> $stable(r_left))
        else $error("syllable count changed during the divide");

    a_drop_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drop <= $signed(DROP_W'(DROP_CAP))))
        else $error("pitch drop above its cap");

endmodule

// ===== bench/pitch_gradient_check.sv =====
// Channel monitor for the syllable pitch gradient block: predicts each syllable result and compares.
module pitch_gradient_check import spg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_cmd,
    input  logic [PITCH_W-1:0]       i_pitch_start,
    input  logic [PITCH_W-1:0]       i_pitch_end,
    input  logic [COUNT_W-1:0]       i_syllable_count,
    input  logic [STRESS_W-1:0]      i_stress_level,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [PITCH_W-1:0]       i_base_pitch,
    input  logic signed [DROP_W-1:0] i_pitch_drop,
    input  logic                     i_last_syllable,
    output int                       o_mismatches,
    output int                       o_outstanding
);

    typedef struct packed {
        logic [PITCH_W-1:0]       base;
        logic signed [DROP_W-1:0] drop;
        logic                     last;
    } t_syllable_pitch;

    // Smallest fall allowed on a non-rising slope, indexed by stress.
    int stress_floor [8] = '{6, 7, 9, 9, 20, 20, 20, 25};

    logic [ACC_W-1:0]        pitch_acc = '0;
    logic signed [ACC_W-1:0] pitch_step = '0;
    logic [COUNT_W-1:0]      syllables_left = '0;
    t_syllable_pitch         expected_pitches [$];
    int                      errors = 0;

    always @(posedge i_clk) begin
        t_syllable_pitch want;
        t_syllable_pitch got;
        int slope;
        int drop;
        if (!i_rst_n) begin
            pitch_acc      = '0;
            pitch_step     = '0;
            syllables_left = '0;
            expected_pitches.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_base_pitch, i_pitch_drop, i_last_syllable};
                if (expected_pitches.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: base_pitch %0d pitch_drop %0d last %0d",
                                 got.base, $signed(got.drop), got.last);
                end else begin
                    want = expected_pitches.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: base_pitch exp %0d got %0d, ",
                                      "pitch_drop exp %0d got %0d, last exp %0d got %0d"},
                                     want.base, got.base, $signed(want.drop),
                                     $signed(got.drop), want.last, got.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_cmd'(i_cmd) == CMD_START) begin
                    slope = (int'(i_pitch_end) - int'(i_pitch_start)) * 256;
                    // Integer division truncates toward zero, as the slope requires.
                    if (i_syllable_count > 1)
                        slope = slope / int'(i_syllable_count);
                    pitch_step     = ACC_W'(slope);
                    pitch_acc      = ACC_W'({i_pitch_start, 8'h00});
                    syllables_left = i_syllable_count;
                end else if (syllables_left != 0) begin
                    slope = pitch_step;
                    // Arithmetic shift gives the integer part rounded toward minus infinity.
                    drop = -(slope >>> FRAC_W);
                    if (slope > 0) begin
                        want.base = pitch_acc[FRAC_W +: PITCH_W];
                        pitch_acc = pitch_acc + pitch_step;
                    end else begin
                        if (drop < stress_floor[i_stress_level])
                            drop = stress_floor[i_stress_level];
                        if (drop > int'(DROP_CAP))
                            drop = int'(DROP_CAP);
                        pitch_acc = pitch_acc + pitch_step;
                        want.base = pitch_acc[FRAC_W +: PITCH_W];
                    end
                    want.drop = DROP_W'(drop);
                    want.last = (syllables_left == 1);
                    syllables_left = syllables_left - 1'b1;
                    expected_pitches.push_back(want);
                end
            end
        end
        o_mismatches  <= errors;
        o_outstanding <= expected_pitches.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Stimulus, clock, reset, watchdog and verdict for the syllable pitch gradient block.
module testbench;
    import spg_pkg::*;

    localparam int RUN_ITEMS  = 1800;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 40;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_cmd = CMD_START;
    logic [PITCH_W-1:0]       i_pitch_start = '0;
    logic [PITCH_W-1:0]       i_pitch_end = '0;
    logic [COUNT_W-1:0]       i_syllable_count = '0;
    logic [STRESS_W-1:0]      i_stress_level = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [PITCH_W-1:0]       o_base_pitch;
    logic signed [DROP_W-1:0] o_pitch_drop;
    logic                     o_last_syllable;

    int mismatches;
    int outstanding;
    int items_sent = 0;
    bit no_gaps = 1'b0;
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;

    syllable_pitch_gradient_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_pitch_start    (i_pitch_start),
        .i_pitch_end      (i_pitch_end),
        .i_syllable_count (i_syllable_count),
        .i_stress_level   (i_stress_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_base_pitch     (o_base_pitch),
        .o_pitch_drop     (o_pitch_drop),
        .o_last_syllable  (o_last_syllable)
    );

    pitch_gradient_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_cmd            (i_cmd),
        .i_pitch_start    (i_pitch_start),
        .i_pitch_end      (i_pitch_end),
        .i_syllable_count (i_syllable_count),
        .i_stress_level   (i_stress_level),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_base_pitch     (o_base_pitch),
        .i_pitch_drop     (o_pitch_drop),
        .i_last_syllable  (o_last_syllable),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [PITCH_W-1:0] start_pitch,
                             input logic [PITCH_W-1:0] end_pitch,
                             input logic [COUNT_W-1:0] count,
                             input logic [STRESS_W-1:0] stress);
        int gap;
        gap = no_gaps ? 0 : idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd            <= cmd;
        i_pitch_start    <= start_pitch;
        i_pitch_end      <= end_pitch;
        i_syllable_count <= count;
        i_stress_level   <= stress;
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (calm_left > 0) begin
            i_stall   <= 1'b0;
            calm_left <= calm_left - 1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 49) == 0)
                calm_left <= $urandom_range(50, 300);
            else
                stall_left <= idle_length();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int count;
        int syllables;
        int r;
        logic [PITCH_W-1:0] start_pitch;
        logic [PITCH_W-1:0] end_pitch;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A syllable item with no run armed is dropped.
        send_item(CMD_SYLLABLE, 8'hA5, 8'h5A, 8'hFF, 3'd7);
        // Steepest rise over a single syllable, then one syllable too many.
        send_item(CMD_START, 8'd0, 8'd255, 8'd1, 3'd7);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd7);
        send_item(CMD_SYLLABLE, 8'd255, 8'd255, 8'd255, 3'd3);
        // Steepest fall: the drop hits the cap.
        send_item(CMD_START, 8'd255, 8'd0, 8'd1, 3'd0);
        send_item(CMD_SYLLABLE, 8'd255, 8'd255, 8'd255, 3'd0);
        // Empty run.
        send_item(CMD_START, 8'd77, 8'd200, 8'd0, 3'd5);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd5);
        // Flat slope takes the falling branch, so each stress floor shows, up to the cap.
        send_item(CMD_START, 8'd128, 8'd128, 8'd8, 3'd0);
        for (int s = 0; s < 8; s++)
            send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, STRESS_W'(s));
        // Uneven division of a fall, truncated toward zero.
        send_item(CMD_START, 8'd17, 8'd10, 8'd3, 3'd0);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd0);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd4);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd7);
        // Uneven rise, cut short by a new run of the largest count.
        send_item(CMD_START, 8'd10, 8'd17, 8'd3, 3'd2);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd1);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd6);
        send_item(CMD_START, 8'd0, 8'd255, 8'd255, 3'd0);
        send_item(CMD_SYLLABLE, 8'd0, 8'd0, 8'd0, 3'd2);

        drain_results();

        while (items_sent < RUN_ITEMS) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 24) == 0)
                drain_results();

            r = $urandom_range(0, 99);
            if (r < 70)
                count = $urandom_range(1, 8);
            else if (r < 80)
                count = 0;
            else if (r < 97)
                count = $urandom_range(9, 40);
            else
                count = $urandom_range(41, 255);

            start_pitch = PITCH_W'($urandom);
            r = $urandom_range(0, 9);
            if (r == 0)
                end_pitch = start_pitch;
            else if (r < 4)
                end_pitch = start_pitch + PITCH_W'($urandom_range(0, 8)) - 8'd4;
            else
                end_pitch = PITCH_W'($urandom);
            send_item(CMD_START, start_pitch, end_pitch, COUNT_W'(count),
                      STRESS_W'($urandom));

            // Most runs are complete; some overrun the count and some stop early.
            syllables = count;
            r = $urandom_range(0, 9);
            if (r == 0)
                syllables = count + $urandom_range(1, 3);
            else if (r == 1 && count > 0)
                syllables = $urandom_range(0, count - 1);
            for (int k = 0; k < syllables; k++)
                send_item(CMD_SYLLABLE, PITCH_W'($urandom), PITCH_W'($urandom),
                          COUNT_W'($urandom), STRESS_W'($urandom));
        end

        no_gaps = 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
